### rtl/ngram_hash_table_index_defines.svh
// assertion macros for the top-level rtl file
`ifndef NGRAM_HASH_TABLE_INDEX_DEFINES_SVH
`define NGRAM_HASH_TABLE_INDEX_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define NGI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define NGI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ngi_pkg.sv
`default_nettype none
package ngi_pkg;

    // actions
    localparam logic [1:0] ACT_HASH = 2'd0;
    localparam logic [1:0] ACT_HEAD = 2'd1;
    localparam logic [1:0] ACT_HIST = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_TOKEN = 2'd1;
    localparam logic [1:0] ST_BAD_ENTRY = 2'd2;
    localparam logic [1:0] ST_UNLOADED  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_MULT_CURRENT  = 3'd0;
    localparam logic [2:0] REG_MULT_PREVIOUS = 3'd1;
    localparam logic [2:0] REG_MULT_OLDER    = 3'd2;
    localparam logic [2:0] REG_EOS_TOKEN     = 3'd3;
    localparam logic [2:0] REG_VOCAB_SIZE    = 3'd4;
    localparam logic [2:0] REG_TABLE_ROWS    = 3'd5;

    // first head that also mixes in the token two back
    localparam int TRIGRAM_FIRST_HEAD = 8;

    typedef struct packed {
        logic [63:0] mult_current;
        logic [63:0] mult_previous;
        logic [63:0] mult_older;
        logic [31:0] eos_token;
        logic [32:0] vocabulary_size;
        logic [62:0] table_rows;
    } cfg_t;

    // command passed from the front to the back
    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  lane;
        logic [31:0] token;
        logic [31:0] prev;
        logic [31:0] prev2;
        logic        tok_ok;
        logic [3:0]  head_index;
        logic [62:0] head_size;
        logic [62:0] head_offset;
    } cmd_t;

endpackage
`default_nettype wire

### rtl/ngram_hash_table_index.sv
// N-gram hash row indexer. A hash beat (action 0) on a lane mixes the token with
// the lane's history by multiply-XOR and returns one table row per head, head 0
// first, last set on the final head; action 1 loads a head entry and returns one
// status beat; action 2 sets a lane's history silently. A front stage reads the
// lane history from a RAM, one beat at a time, and feeds a two-entry queue; the
// back runs six 32x32 partial products on one multiplier and then a radix-2
// remainder unit per head: a loaded, valid head goes through setup, 64 division
// steps, fold, offset add and output, a flagged head through setup and output.
// Results sit in an output register so the back keeps working while a finished
// beat waits downstream.
`default_nettype none
`include "ngram_hash_table_index_defines.svh"
module ngram_hash_table_index import ngi_pkg::*; #(
    parameter int LANES = 8,
    parameter int HEADS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [2:0]  s_lane,
    input  wire logic [31:0] s_token,
    input  wire logic [31:0] s_older_token,
    input  wire logic [3:0]  s_head_index,
    input  wire logic [62:0] s_head_size,
    input  wire logic [62:0] s_head_offset,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_out_lane,
    output logic [3:0]       m_out_head,
    output logic [62:0]      m_row_index,
    output logic [1:0]       m_status,
    output logic             m_last
);
    cfg_t cfg_reg;
    cmd_t q_din;
    cmd_t q_dout;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mult_current    <= 64'd0;
            cfg_reg.mult_previous   <= 64'd0;
            cfg_reg.mult_older      <= 64'd0;
            cfg_reg.eos_token       <= 32'd0;
            cfg_reg.vocabulary_size <= 33'd1;
            cfg_reg.table_rows      <= 63'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MULT_CURRENT:  cfg_reg.mult_current    <= cfg_wr_data;
                REG_MULT_PREVIOUS: cfg_reg.mult_previous   <= cfg_wr_data;
                REG_MULT_OLDER:    cfg_reg.mult_older      <= cfg_wr_data;
                REG_EOS_TOKEN:     cfg_reg.eos_token       <= cfg_wr_data[31:0];
                REG_VOCAB_SIZE:    cfg_reg.vocabulary_size <= cfg_wr_data[32:0];
                REG_TABLE_ROWS:    cfg_reg.table_rows      <= cfg_wr_data[62:0];
                default: ;
            endcase
        end
    end

    // front: history lookup and classification
    ngi_front #(.LANES(LANES)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_lane        (s_lane),
        .s_token       (s_token),
        .s_older_token (s_older_token),
        .s_head_index  (s_head_index),
        .s_head_size   (s_head_size),
        .s_head_offset (s_head_offset),
        .cmd           (q_din),
        .push          (q_push),
        .full          (q_full)
    );

    // command queue
    ngi_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .valid   (q_valid)
    );

    // back: hashing, head table and result register
    ngi_back #(.HEADS(HEADS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (q_dout),
        .cmd_valid   (q_valid),
        .cmd_pop     (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_lane  (m_out_lane),
        .m_out_head  (m_out_head),
        .m_row_index (m_row_index),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    // checks
    `NGI_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full, "command pushed into full queue")
    `NGI_ASSERT_IMP(a_row_in_table, m_valid && m_status == ST_OK, m_row_index < cfg_reg.table_rows, "row beyond table")
    `NGI_ASSERT_NXT(a_front_one_beat, s_valid && s_ready, !s_ready, "front took a second beat while busy")

endmodule
`default_nettype wire

### rtl/ngi_ram.sv
`default_nettype none
module ngi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/ngi_fifo.sv
`default_nettype none
module ngi_fifo import ngi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t din,
    output logic      full,
    input  wire logic pop,
    output cmd_t      dout,
    output logic      valid
);
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign dout  = slot_reg[rd_ptr_reg];

    // two-entry queue between front and back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= din;
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/ngi_front.sv
`default_nettype none
module ngi_front import ngi_pkg::*; #(
    parameter int LANES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [2:0]  s_lane,
    input  wire logic [31:0] s_token,
    input  wire logic [31:0] s_older_token,
    input  wire logic [3:0]  s_head_index,
    input  wire logic [62:0] s_head_size,
    input  wire logic [62:0] s_head_offset,
    output cmd_t             cmd,
    output logic             push,
    input  wire logic        full
);
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic          busy_reg;
    logic [1:0]    act_reg;
    logic [2:0]    lane_reg;
    logic [LW-1:0] idx_reg;
    logic [31:0]   tok_reg;
    logic [31:0]   old_in_reg;
    logic [3:0]    hidx_reg;
    logic [62:0]   hsize_reg;
    logic [62:0]   hoff_reg;
    logic          in_range_reg;
    logic          vq_reg;
    logic          vld_reg [LANES];

    logic          accept;
    logic [LW-1:0] s_idx;
    logic [63:0]   rdata;
    logic [31:0]   prev;
    logic [31:0]   old;
    logic          tok_ok;
    logic          need_push;
    logic          done;
    logic          hist_we;
    logic [63:0]   hist_wdata;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign s_idx   = LW'({5'b0, s_lane});

    // lane history, previous token in the upper half
    ngi_ram #(.WIDTH(64), .DEPTH(LANES)) u_hist (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (idx_reg),
        .wdata (hist_wdata),
        .re    (accept),
        .raddr (s_idx),
        .rdata (rdata)
    );

    // classify the held beat against the history read
    always_comb begin
        prev      = vq_reg ? rdata[63:32] : 32'd0;
        old       = vq_reg ? rdata[31:0]  : 32'd0;
        tok_ok    = ({1'b0, tok_reg} < cfg.vocabulary_size)
                 && ({1'b0, prev} < cfg.vocabulary_size)
                 && ({1'b0, old} < cfg.vocabulary_size);
        need_push = in_range_reg && (act_reg == ACT_HASH || act_reg == ACT_HEAD);
        done      = busy_reg && (!need_push || !full);
        push      = busy_reg && need_push && !full;
        hist_we   = done && in_range_reg
                 && (act_reg == ACT_HIST || (act_reg == ACT_HASH && tok_ok));
        hist_wdata = (act_reg == ACT_HIST) ? {tok_reg, old_in_reg} : {tok_reg, prev};

        cmd.action      = act_reg;
        cmd.lane        = lane_reg;
        cmd.token       = tok_reg;
        cmd.prev        = prev;
        cmd.prev2       = (prev == cfg.eos_token) ? cfg.eos_token : old;
        cmd.tok_ok      = tok_ok;
        cmd.head_index  = hidx_reg;
        cmd.head_size   = hsize_reg;
        cmd.head_offset = hoff_reg;
    end

    // capture beat, hold until classified
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg      <= s_action;
            lane_reg     <= s_lane;
            idx_reg      <= s_idx;
            tok_reg      <= s_token;
            old_in_reg   <= s_older_token;
            hidx_reg     <= s_head_index;
            hsize_reg    <= s_head_size;
            hoff_reg     <= s_head_offset;
            in_range_reg <= ({29'b0, s_lane} < LANES);
        end
    end

    // busy flag and history valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            vq_reg   <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
                vq_reg   <= vld_reg[s_idx];
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (hist_we) begin
                vld_reg[idx_reg] <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/ngi_back.sv
`default_nettype none
module ngi_back import ngi_pkg::*; #(
    parameter int HEADS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire cmd_t        cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_out_lane,
    output logic [3:0]       m_out_head,
    output logic [62:0]      m_row_index,
    output logic [1:0]       m_status,
    output logic             m_last
);
    localparam int HW = $clog2(HEADS);
    localparam logic [HW-1:0] LAST_HEAD = HW'(HEADS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]    state_reg;
    cmd_t          cur_reg;
    logic [2:0]    step_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   acc0_reg;
    logic [63:0]   acc1_reg;
    logic [63:0]   acc2_reg;
    logic [HW-1:0] h_reg;
    logic          neg_reg;
    logic [63:0]   mag_reg;
    logic [63:0]   rem_reg;
    logic [62:0]   size_reg;
    logic [62:0]   base_reg;
    logic [5:0]    cnt_reg;
    logic [1:0]    res_status_reg;
    logic [62:0]   res_row_reg;
    logic [3:0]    res_head_reg;
    logic          res_last_reg;
    logic          m_valid_reg;
    logic [2:0]    m_lane_reg;
    logic [3:0]    m_head_reg;
    logic [62:0]   m_row_reg;
    logic [1:0]    m_status_reg;
    logic          m_last_reg;
    logic [62:0]   mod_tab_reg  [HEADS];
    logic [62:0]   base_tab_reg [HEADS];

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   product;
    logic [2:0]    prev_step;
    logic [63:0]   addend;
    logic [62:0]   hmod;
    logic [62:0]   hbase;
    logic [63:0]   mixed;
    logic [63:0]   bits;
    logic          wr_ok;
    logic [HW-1:0] wr_idx;
    logic          out_free;
    logic          emit;
    logic [63:0]   sh;
    logic          ge;

    function automatic logic entry_ok(logic [62:0] size, logic [62:0] off,
                                      logic [62:0] rows);
        return (size != 63'd0) && (off < rows) && (size <= rows - off);
    endfunction

    assign m_valid     = m_valid_reg;
    assign m_out_lane  = m_lane_reg;
    assign m_out_head  = m_head_reg;
    assign m_row_index = m_row_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;

    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg == S_EMIT) && out_free;

    // partial product select: two 32-bit halves per term
    always_comb begin
        unique case (step_reg)
            3'd0:    begin mul_a = cur_reg.token; mul_b = cfg.mult_current[31:0];   end
            3'd1:    begin mul_a = cur_reg.token; mul_b = cfg.mult_current[63:32];  end
            3'd2:    begin mul_a = cur_reg.prev;  mul_b = cfg.mult_previous[31:0];  end
            3'd3:    begin mul_a = cur_reg.prev;  mul_b = cfg.mult_previous[63:32]; end
            3'd4:    begin mul_a = cur_reg.prev2; mul_b = cfg.mult_older[31:0];     end
            3'd5:    begin mul_a = cur_reg.prev2; mul_b = cfg.mult_older[63:32];    end
            default: begin mul_a = 32'd0;         mul_b = 32'd0;                    end
        endcase
        product   = {32'd0, mul_a} * {32'd0, mul_b};
        prev_step = step_reg - 3'd1;
        addend    = prev_step[0] ? {prod_reg[31:0], 32'd0} : prod_reg;
    end

    // head entry, mix select and division step
    always_comb begin
        hmod   = mod_tab_reg[h_reg];
        hbase  = base_tab_reg[h_reg];
        mixed  = acc0_reg ^ acc1_reg;
        bits   = (32'(h_reg) >= TRIGRAM_FIRST_HEAD) ? (mixed ^ acc2_reg) : mixed;
        wr_idx = HW'(cmd.head_index);
        wr_ok  = (32'(cmd.head_index) < HEADS)
              && entry_ok(cmd.head_size, cmd.head_offset, cfg.table_rows);
        sh     = {rem_reg[62:0], mag_reg[63]};
        ge     = (sh >= {1'b0, size_reg});
    end

    // sequencer: head writes, or multiply, then one restoring division per loaded, valid head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HEADS; i++) begin
                mod_tab_reg[i]  <= 63'd0;
                base_tab_reg[i] <= 63'd0;
            end
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cur_reg <= cmd;
                        if (cmd.action == ACT_HEAD) begin
                            if (wr_ok) begin
                                mod_tab_reg[wr_idx]  <= cmd.head_size;
                                base_tab_reg[wr_idx] <= cmd.head_offset;
                            end
                            res_status_reg <= wr_ok ? ST_OK : ST_BAD_ENTRY;
                            res_row_reg    <= 63'd0;
                            res_head_reg   <= cmd.head_index;
                            res_last_reg   <= 1'b1;
                            state_reg      <= S_EMIT;
                        end else begin
                            step_reg  <= 3'd0;
                            acc0_reg  <= 64'd0;
                            acc1_reg  <= 64'd0;
                            acc2_reg  <= 64'd0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg <= product;
                    if (step_reg != 3'd0) begin
                        case (prev_step[2:1])
                            2'd0:    acc0_reg <= acc0_reg + addend;
                            2'd1:    acc1_reg <= acc1_reg + addend;
                            default: acc2_reg <= acc2_reg + addend;
                        endcase
                    end
                    if (step_reg == 3'd6) begin
                        h_reg     <= '0;
                        state_reg <= S_HEAD;
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_HEAD: begin
                    res_head_reg <= 4'(h_reg);
                    res_last_reg <= (h_reg == LAST_HEAD);
                    res_row_reg  <= 63'd0;
                    if (!cur_reg.tok_ok) begin
                        res_status_reg <= ST_BAD_TOKEN;
                        state_reg      <= S_EMIT;
                    end else if (hmod == 63'd0) begin
                        res_status_reg <= ST_UNLOADED;
                        state_reg      <= S_EMIT;
                    end else if (!entry_ok(hmod, hbase, cfg.table_rows)) begin
                        res_status_reg <= ST_BAD_ENTRY;
                        state_reg      <= S_EMIT;
                    end else begin
                        neg_reg   <= bits[63];
                        mag_reg   <= bits[63] ? (~bits + 64'd1) : bits;
                        rem_reg   <= 64'd0;
                        size_reg  <= hmod;
                        base_reg  <= hbase;
                        cnt_reg   <= 6'd63;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= ge ? (sh - {1'b0, size_reg}) : sh;
                    mag_reg <= {mag_reg[62:0], 1'b0};
                    if (cnt_reg == 6'd0) begin
                        state_reg <= S_FIX;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_FIX: begin
                    // negative mix: fold the remainder back into range
                    if (neg_reg && rem_reg != 64'd0) begin
                        rem_reg <= {1'b0, size_reg - rem_reg[62:0]};
                    end
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    res_row_reg    <= rem_reg[62:0] + base_reg;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_lane_reg   <= cur_reg.lane;
                        m_head_reg   <= res_head_reg;
                        m_row_reg    <= res_row_reg;
                        m_status_reg <= res_status_reg;
                        m_last_reg   <= res_last_reg;
                        if (res_last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            h_reg     <= h_reg + 1'b1;
                            state_reg <= S_HEAD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

// expected row indexes per head and lane, checked in order
class row_scoreboard;
    localparam int NLANES = 8;
    localparam int NHEADS = 16;

    logic [63:0] mult_current, mult_previous, mult_older;
    logic [31:0] eos_token;
    logic [32:0] vocabulary_size;
    logic [62:0] table_rows;
    logic [31:0] lane_previous [NLANES];
    logic [31:0] lane_older [NLANES];
    logic [62:0] head_modulus [NHEADS];
    logic [62:0] head_base [NHEADS];
    logic [72:0] pending_rows [$];
    int mismatches;
    int beats_checked;

    function new();
        mult_current = '0;
        mult_previous = '0;
        mult_older = '0;
        eos_token = '0;
        vocabulary_size = 33'd1;
        table_rows = 63'd1;
        mismatches = 0;
        beats_checked = 0;
        for (int i = 0; i < NLANES; i++) begin
            lane_previous[i] = '0;
            lane_older[i] = '0;
        end
        for (int i = 0; i < NHEADS; i++) begin
            head_modulus[i] = '0;
            head_base[i] = '0;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            ngi_pkg::REG_MULT_CURRENT: mult_current = val;
            ngi_pkg::REG_MULT_PREVIOUS: mult_previous = val;
            ngi_pkg::REG_MULT_OLDER: mult_older = val;
            ngi_pkg::REG_EOS_TOKEN: eos_token = val[31:0];
            ngi_pkg::REG_VOCAB_SIZE: vocabulary_size = val[32:0];
            ngi_pkg::REG_TABLE_ROWS: table_rows = val[62:0];
            default: ;
        endcase
    endfunction

    function bit entry_fits(logic [62:0] size, logic [62:0] offset);
        return size != 0 && offset < table_rows && size <= table_rows - offset;
    endfunction

    // remainder of a signed 64-bit value, always non-negative
    function logic [63:0] signed_rem(logic [63:0] bits, logic [63:0] size);
        logic [63:0] r;
        if (!bits[63]) return bits % size;
        r = (~bits + 64'd1) % size;
        return (r == 0) ? 64'd0 : size - r;
    endfunction

    function void push(logic [2:0] lane, logic [3:0] head, logic [62:0] row,
                       logic [1:0] status, logic last);
        pending_rows.insert(pending_rows.size(), {lane, head, row, status, last});
    endfunction

    // note one accepted input beat
    function void note_input(logic [1:0] action, logic [2:0] lane, logic [31:0] token,
                             logic [31:0] older, logic [3:0] hidx,
                             logic [62:0] hsize, logic [62:0] hoff);
        logic [31:0] prev, old, prev2;
        logic [63:0] mixed, tri_mix, bits;
        bit ok;
        case (action)
            ngi_pkg::ACT_HASH: begin
                prev = lane_previous[lane];
                old = lane_older[lane];
                ok = {1'b0, token} < vocabulary_size && {1'b0, prev} < vocabulary_size
                     && {1'b0, old} < vocabulary_size;
                prev2 = (prev == eos_token) ? eos_token : old;
                mixed = ({32'd0, token} * mult_current) ^ ({32'd0, prev} * mult_previous);
                tri_mix = mixed ^ ({32'd0, prev2} * mult_older);
                for (int h = 0; h < NHEADS; h++) begin
                    if (!ok)
                        push(lane, h[3:0], '0, ngi_pkg::ST_BAD_TOKEN, h == NHEADS - 1);
                    else if (head_modulus[h] == 0)
                        push(lane, h[3:0], '0, ngi_pkg::ST_UNLOADED, h == NHEADS - 1);
                    else if (!entry_fits(head_modulus[h], head_base[h]))
                        push(lane, h[3:0], '0, ngi_pkg::ST_BAD_ENTRY, h == NHEADS - 1);
                    else begin
                        bits = (h < ngi_pkg::TRIGRAM_FIRST_HEAD) ? mixed : tri_mix;
                        bits = signed_rem(bits, {1'b0, head_modulus[h]}) + head_base[h];
                        push(lane, h[3:0], bits[62:0], ngi_pkg::ST_OK, h == NHEADS - 1);
                    end
                end
                if (ok) begin
                    lane_older[lane] = prev;
                    lane_previous[lane] = token;
                end
            end
            ngi_pkg::ACT_HEAD: begin
                if (entry_fits(hsize, hoff)) begin
                    head_modulus[hidx] = hsize;
                    head_base[hidx] = hoff;
                    push(lane, hidx, '0, ngi_pkg::ST_OK, 1'b1);
                end else begin
                    push(lane, hidx, '0, ngi_pkg::ST_BAD_ENTRY, 1'b1);
                end
            end
            ngi_pkg::ACT_HIST: begin
                lane_previous[lane] = token;
                lane_older[lane] = older;
            end
            default: ;
        endcase
    endfunction

    function void report(string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endfunction

    // check one accepted result beat
    function void check_result(logic [2:0] lane, logic [3:0] head, logic [62:0] row,
                               logic [1:0] status, logic last);
        logic [72:0] e;
        beats_checked++;
        if (pending_rows.size() == 0) begin
            report($sformatf("unexpected beat lane %0d head %0d", lane, head));
            return;
        end
        e = pending_rows.pop_front();
        if (lane !== e[72:70])
            report($sformatf("lane %0d, want %0d", lane, e[72:70]));
        if (head !== e[69:66])
            report($sformatf("head %0d, want %0d", head, e[69:66]));
        if (row !== e[65:3])
            report($sformatf("head %0d row %0d, want %0d", head, row, e[65:3]));
        if (status !== e[2:1])
            report($sformatf("head %0d status %0d, want %0d", head, status, e[2:1]));
        if (last !== e[0])
            report($sformatf("head %0d last %0d, want %0d", head, last, e[0]));
    endfunction
endclass

module testbench;
    import ngi_pkg::*;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [2:0] cfg_index;
    logic [63:0] cfg_wr_data;
    logic s_valid, s_ready;
    logic [1:0] s_action;
    logic [2:0] s_lane;
    logic [31:0] s_token, s_older_token;
    logic [3:0] s_head_index;
    logic [62:0] s_head_size, s_head_offset;
    logic m_valid, m_ready;
    logic [2:0] m_out_lane;
    logic [3:0] m_out_head;
    logic [62:0] m_row_index;
    logic [1:0] m_status;
    logic m_last;

    row_scoreboard rows = new();
    int send_idle_pct, recv_stall_pct;
    int hold_off_cycles;
    int hash_beats;

    ngram_hash_table_index u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

    // result side: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                rows.check_result(m_out_lane, m_out_head, m_row_index, m_status, m_last);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rows.write_reg(idx, val);
    endtask

    // offer one beat and hold it until accepted
    task automatic send_beat(logic [1:0] act, logic [2:0] lane, logic [31:0] tok,
                             logic [31:0] older, logic [3:0] hidx,
                             logic [62:0] hsize, logic [62:0] hoff);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_lane <= lane;
        s_token <= tok;
        s_older_token <= older;
        s_head_index <= hidx;
        s_head_size <= hsize;
        s_head_offset <= hoff;
        do @(posedge aclk); while (!s_ready);
        rows.note_input(act, lane, tok, older, hidx, hsize, hoff);
        if (act == ACT_HASH) hash_beats++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (rows.pending_rows.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    function automatic logic [62:0] rand63();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_token();
        logic [32:0] v;
        v = rows.vocabulary_size;
        case ($urandom_range(9))
            0: return $urandom;
            1: return rows.eos_token;
            2: return (v > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0] - 1;
            default: return (v > 33'hFFFF_FFFF) ? $urandom : $urandom_range(v - 1, 0);
        endcase
    endfunction

    // load head entries that fit the current table size
    task automatic load_heads();
        logic [62:0] sz, off;
        for (int h = 0; h < 16; h++) begin
            case ($urandom_range(3))
                0: sz = $urandom_range(5, 1);
                1: sz = rows.table_rows;
                default: sz = (rows.table_rows > 63'hFFFF_FFFF) ?
                              {31'd0, $urandom} + 1 : $urandom_range(rows.table_rows, 1);
            endcase
            if (sz > rows.table_rows) sz = rows.table_rows;
            if (sz == 0) sz = 1;
            off = (rows.table_rows - sz == 0) ? 63'd0 :
                  rand63() % (rows.table_rows - sz + 1);
            send_beat(ACT_HEAD, $urandom_range(7), 0, 0, h[3:0], sz, off);
        end
    endtask

    task automatic random_items(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 70)
                send_beat(ACT_HASH, $urandom_range(7), rand_token(), $urandom,
                          $urandom, rand63(), rand63());
            else if (r < 82)
                send_beat(ACT_HIST, $urandom_range(7), rand_token(), rand_token(),
                          $urandom, rand63(), rand63());
            else if (r < 95)
                send_beat(ACT_HEAD, $urandom_range(7), $urandom, $urandom,
                          $urandom, ($urandom_range(3) == 0) ? rand63() :
                          $urandom_range(40), $urandom_range(3) == 0 ? rand63() :
                          $urandom_range(40));
            else
                send_beat(ACT_NOP, $urandom_range(7), $urandom, $urandom,
                          $urandom, rand63(), rand63());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_action = '0;
        s_lane = '0;
        s_token = '0;
        s_older_token = '0;
        s_head_index = '0;
        s_head_size = '0;
        s_head_offset = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        hash_beats = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset state gives unloaded heads and bad tokens
        send_beat(ACT_HASH, 3'd0, 32'd0, 0, 0, 0, 0);
        send_beat(ACT_HASH, 3'd7, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_beat(ACT_HEAD, 3'd1, 0, 0, 4'd0, 63'd0, 63'd0);
        send_beat(ACT_HEAD, 3'd2, 0, 0, 4'd15, 63'd1, 63'd0);
        send_beat(ACT_NOP, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, '1, '1);
        drain();

        write_cfg(REG_MULT_CURRENT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cfg(REG_MULT_PREVIOUS, 64'h9E37_79B9_7F4A_7C15);
        write_cfg(REG_MULT_OLDER, 64'h8000_0000_0000_0001);
        write_cfg(REG_EOS_TOKEN, 64'd2);
        write_cfg(REG_VOCAB_SIZE, 64'h1_0000_0000);
        write_cfg(REG_TABLE_ROWS, 64'h7FFF_FFFF_FFFF_FFFF);
        // extremes of head entries: full table, last row, size too big
        send_beat(ACT_HEAD, 3'd0, 0, 0, 4'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'd0);
        send_beat(ACT_HEAD, 3'd0, 0, 0, 4'd9, 63'd1, 63'h7FFF_FFFF_FFFF_FFFE);
        send_beat(ACT_HEAD, 3'd0, 0, 0, 4'd10, 63'd2, 63'h7FFF_FFFF_FFFF_FFFE);
        send_beat(ACT_HEAD, 3'd0, 0, 0, 4'd11, 63'd3, 63'h7FFF_FFFF_FFFF_FFFF);
        send_beat(ACT_HEAD, 3'd0, 0, 0, 4'd8, 63'd7, 63'd100);
        // end-of-sequence cuts the trigram, then max tokens
        send_beat(ACT_HIST, 3'd4, 32'd2, 32'hFFFF_FFFF, 0, 0, 0);
        send_beat(ACT_HASH, 3'd4, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_beat(ACT_HASH, 3'd4, 32'd2, 0, 0, 0, 0);
        send_beat(ACT_HASH, 3'd4, 32'd0, 0, 0, 0, 0);
        drain();
        // shrink the table so loaded entries go stale, tiny vocabulary
        write_cfg(REG_TABLE_ROWS, 64'd50);
        write_cfg(REG_VOCAB_SIZE, 64'd1);
        send_beat(ACT_HASH, 3'd3, 32'd0, 0, 0, 0, 0);
        drain();
        write_cfg(REG_VOCAB_SIZE, 64'd1000);
        send_beat(ACT_HASH, 3'd3, 32'd999, 0, 0, 0, 0);
        send_beat(ACT_HASH, 3'd3, 32'd1000, 0, 0, 0, 0);
        drain();

        // random phases with differing idle mixes and settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                3: begin send_idle_pct = 22; recv_stall_pct = 22; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_cfg(REG_MULT_CURRENT, {$urandom, $urandom});
            write_cfg(REG_MULT_PREVIOUS, (ph == 1) ? 64'd0 : {$urandom, $urandom});
            write_cfg(REG_MULT_OLDER, {$urandom, $urandom});
            write_cfg(REG_EOS_TOKEN, $urandom_range(3));
            write_cfg(REG_VOCAB_SIZE, (ph == 2) ? 64'h1_0000_0000 : $urandom_range(200, 1));
            write_cfg(REG_TABLE_ROWS, (ph == 3) ? {1'b0, rand63()} : $urandom_range(60, 1));
            if (ph == 4) hold_off_cycles = 3000;
            load_heads();
            random_items(13);
            drain();
        end

        $display("checked %0d result beats from %0d hash beats over five idle mixes",
                 rows.beats_checked, hash_beats);
        if (rows.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", rows.mismatches);
            $display("FAIL");
        end
        $finish;
    end
endmodule

### ngram_hash_table_index.f
+incdir+rtl
rtl/ngi_pkg.sv
rtl/ngi_ram.sv
rtl/ngi_fifo.sv
rtl/ngi_front.sv
rtl/ngi_back.sv
rtl/ngram_hash_table_index.sv
sim/testbench.sv
